>>> design/nsr_pkg.sv
`default_nettype none
package nsr_pkg;
  localparam int IN_W = 32;
  localparam int MANT_W = 63;
  localparam int LOG_BITS = 40;
  localparam int LG_W = 46;
  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;
endpackage
`default_nettype wire

>>> design/newton_square_root_unit.sv
// Fully pipelined Q16.16 square root. One request enters per clock whenever
// start is high; busy is always low. Each result appears on out_root and
// out_invalid for one cycle with out_valid. The pipeline is made of the
// natural-log seed (40 two-stage squaring steps and a three-stage scaling
// multiply) followed by one bit-per-stage restoring divider and one update
// stage for every Babylonian iteration. Operands at most 1.0 give invalid
// high and a root of 0. The receiver cannot stall.
`default_nettype none
module newton_square_root_unit #(
  parameter int ITERATIONS = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] in_value,
  output logic             busy,
  output logic             out_valid,
  output logic [31:0]      out_root,
  output logic             out_invalid
);
  localparam int NW = nsr_pkg::IN_W + FRAC_BITS;
  localparam int SH = nsr_pkg::LOG_BITS - FRAC_BITS;
  localparam int NB = nsr_pkg::LOG_BITS;
  localparam int LAT = 87 + ITERATIONS * (NW + 1);

  logic vld_r [LAT];

  logic [31:0] v0_r;
  logic        inv0_r;
  logic [31:0] v1_r;
  logic        inv1_r;
  logic [4:0]  n1_r;
  logic [4:0]  n1_nxt;

  logic [nsr_pkg::MANT_W-1:0] m_r [NB+1];
  logic [NB-1:0]              frac_r [NB+1];
  logic [4:0]                 n_r [NB+1];
  logic [31:0]                v_r [NB+1];
  logic                       inv_r [NB+1];

  logic [63:0]   p00_r [NB];
  logic [62:0]   p01_r [NB];
  logic [61:0]   p11_r [NB];
  logic [NB-1:0] fa_r [NB];
  logic [4:0]    na_r [NB];
  logic [31:0]   va_r [NB];
  logic          inva_r [NB];

  logic [nsr_pkg::LG_W-1:0] lg;
  logic [63:0] q00_r, q01_r;
  logic [45:0] q10_r, q11_r;
  logic [31:0] vm1_r, vm2_r;
  logic        invm1_r, invm2_r;
  logic [65:0] mid;
  logic [63:0] hi_nxt, hi_r, rnd;
  logic [NW-1:0] seed;

  logic [NW-1:0] rin_r [ITERATIONS+1];
  logic [NW-1:0] numin_r [ITERATIONS+1];
  logic          invin_r [ITERATIONS+1];

  logic [NW-1:0] rem_r [ITERATIONS][NW];
  logic [NW-1:0] quo_r [ITERATIONS][NW];
  logic [NW-1:0] dv_r [ITERATIONS][NW];
  logic [NW-1:0] num_r [ITERATIONS][NW];
  logic          dinv_r [ITERATIONS][NW];

  logic [31:0] root_r;
  logic        invalid_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= start;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    v0_r <= in_value;
    inv0_r <= ({1'b0, in_value} <= (33'd1 << FRAC_BITS));
  end

  always_comb begin
    n1_nxt = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v0_r[i]) n1_nxt = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    v1_r <= v0_r;
    inv1_r <= inv0_r;
    n1_r <= n1_nxt;
  end

  always_ff @(posedge clk) begin
    m_r[0] <= {31'd0, v1_r} << (6'd62 - {1'b0, n1_r});
    frac_r[0] <= '0;
    n_r[0] <= n1_r;
    v_r[0] <= v1_r;
    inv_r[0] <= inv1_r;
  end

  for (genvar k = 0; k < NB; k++) begin : g_sq
    logic [125:0] sq;
    logic [63:0]  m2;

    always_ff @(posedge clk) begin
      p00_r[k] <= m_r[k][31:0] * m_r[k][31:0];
      p01_r[k] <= 63'(m_r[k][31:0]) * 63'(m_r[k][62:32]);
      p11_r[k] <= m_r[k][62:32] * m_r[k][62:32];
      fa_r[k] <= frac_r[k];
      na_r[k] <= n_r[k];
      va_r[k] <= v_r[k];
      inva_r[k] <= inv_r[k];
    end

    always_comb begin
      sq = {p11_r[k], 64'd0} + {30'd0, p01_r[k], 33'd0} + {62'd0, p00_r[k]};
      m2 = sq[125:62];
    end

    always_ff @(posedge clk) begin
      m_r[k+1] <= m2[63] ? m2[63:1] : m2[62:0];
      frac_r[k+1] <= {fa_r[k][NB-2:0], m2[63]};
      n_r[k+1] <= na_r[k];
      v_r[k+1] <= va_r[k];
      inv_r[k+1] <= inva_r[k];
    end
  end

  assign lg = {1'b0, 5'(n_r[NB] - 5'(FRAC_BITS)), frac_r[NB]};

  always_ff @(posedge clk) begin
    q00_r <= lg[31:0] * nsr_pkg::LN2_Q64[31:0];
    q01_r <= lg[31:0] * nsr_pkg::LN2_Q64[63:32];
    q10_r <= lg[45:32] * nsr_pkg::LN2_Q64[31:0];
    q11_r <= lg[45:32] * nsr_pkg::LN2_Q64[63:32];
    vm1_r <= v_r[NB];
    invm1_r <= inv_r[NB];
  end

  always_comb begin
    mid = {2'd0, q01_r} + {20'd0, q10_r} + {34'd0, q00_r[63:32]};
    hi_nxt = {18'd0, q11_r} + {30'd0, mid[65:32]};
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    vm2_r <= vm1_r;
    invm2_r <= invm1_r;
  end

  always_comb begin
    rnd = hi_r + (64'd1 << (SH - 1));
    seed = NW'(rnd >> SH);
  end

  always_ff @(posedge clk) begin
    rin_r[0] <= (seed == '0) ? NW'(1) : seed;
    numin_r[0] <= {vm2_r, FRAC_BITS'(0)};
    invin_r[0] <= invm2_r;
  end

  for (genvar it = 0; it < ITERATIONS; it++) begin : g_it
    for (genvar b = 0; b < NW; b++) begin : g_bit
      logic [NW-1:0] rem_in, quo_in, dv_in, num_in;
      logic          inv_in;
      logic [NW:0]   trial;
      logic          take;

      if (b == 0) begin : g_first
        assign rem_in = '0;
        assign quo_in = '0;
        assign dv_in = rin_r[it];
        assign num_in = numin_r[it];
        assign inv_in = invin_r[it];
      end else begin : g_next
        assign rem_in = rem_r[it][b-1];
        assign quo_in = quo_r[it][b-1];
        assign dv_in = dv_r[it][b-1];
        assign num_in = num_r[it][b-1];
        assign inv_in = dinv_r[it][b-1];
      end

      always_comb begin
        trial = {rem_in, num_in[NW-1-b]};
        take = (trial >= {1'b0, dv_in});
      end

      always_ff @(posedge clk) begin
        rem_r[it][b] <= take ? NW'(trial - {1'b0, dv_in}) : trial[NW-1:0];
        quo_r[it][b] <= {quo_in[NW-2:0], take};
        dv_r[it][b] <= dv_in;
        num_r[it][b] <= num_in;
        dinv_r[it][b] <= inv_in;
      end
    end

    logic [NW:0]   rsum;
    logic [NW-1:0] rnew;

    always_comb begin
      rsum = {1'b0, dv_r[it][NW-1]} + {1'b0, quo_r[it][NW-1]};
      rnew = rsum[NW:1];
    end

    always_ff @(posedge clk) begin
      rin_r[it+1] <= (rnew == '0) ? NW'(1) : rnew;
      numin_r[it+1] <= num_r[it][NW-1];
      invin_r[it+1] <= dinv_r[it][NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (invin_r[ITERATIONS]) begin
      root_r <= '0;
    end else if (|rin_r[ITERATIONS][NW-1:32]) begin
      root_r <= '1;
    end else begin
      root_r <= rin_r[ITERATIONS][31:0];
    end
    invalid_r <= invin_r[ITERATIONS];
  end

  assign out_valid = vld_r[LAT-1];
  assign out_root = root_r;
  assign out_invalid = invalid_r;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT)) else $error("Result without a request.");
  a_inv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_root == 32'd0) else $error("Invalid root not zero.");
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_invalid |-> out_root != 32'd0) else $error("Valid root is zero.");
endmodule
`default_nettype wire

>>> tb/sqrt_result_checker.sv
`timescale 1ns / 100ps
module sqrt_result_checker #(
  parameter int ITERATIONS = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] in_value,
  input  wire logic        busy,
  input  wire logic        out_valid,
  input  wire logic [31:0] out_root,
  input  wire logic        out_invalid,
  output int               errors,
  output int               outstanding,
  output int               roots_seen,
  output int               invalids_seen
);
  typedef struct packed {
    logic [31:0] root;
    logic        invalid;
  } root_result_t;

  root_result_t pending_roots[$];

  function automatic logic [63:0] ln_seed_of(input logic [63:0] v);
    int n;
    logic [63:0] m, bits, lg, hi;
    logic [127:0] p;
    n = 0;
    while (n < 63 && (v >> (n + 1)) != 0) n++;
    m = v << (62 - n);
    bits = 0;
    for (int i = 0; i < nsr_pkg::LOG_BITS; i++) begin
      p = m * m;
      m = p[125:62];
      bits = bits << 1;
      if (m[63]) begin
        bits[0] = 1'b1;
        m = m >> 1;
      end
    end
    lg = (64'(n - FRAC_BITS) << nsr_pkg::LOG_BITS) | bits;
    p = lg * nsr_pkg::LN2_Q64;
    hi = p[127:64];
    return (hi + (64'd1 << (104 - FRAC_BITS - 64 - 1))) >> (104 - FRAC_BITS - 64);
  endfunction

  function automatic root_result_t predict_root(input logic [31:0] x);
    root_result_t res;
    logic [63:0] num, r;
    if (64'(x) <= (64'd1 << FRAC_BITS)) begin
      res.root = '0;
      res.invalid = 1'b1;
      return res;
    end
    num = 64'(x) << FRAC_BITS;
    r = ln_seed_of(64'(x));
    for (int i = 0; i < ITERATIONS; i++) begin
      if (r == 0) r = 1;
      r = (r + num / r) >> 1;
    end
    res.root = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    res.invalid = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin
    root_result_t want;
    if (rst_n && start && !busy) pending_roots.push_back(predict_root(in_value));
    if (rst_n && out_valid) begin
      roots_seen++;
      if (out_invalid) invalids_seen++;
      if (pending_roots.size() == 0) begin
        errors++;
        $display("%0t: unexpected result root=%h invalid=%b", $time, out_root, out_invalid);
      end else begin
        want = pending_roots.pop_front();
        if (want.root !== out_root) begin
          errors++;
          $display("%0t: root expected %h actual %h", $time, want.root, out_root);
        end
        if (want.invalid !== out_invalid) begin
          errors++;
          $display("%0t: invalid expected %b actual %b", $time, want.invalid, out_invalid);
        end
      end
    end
    outstanding = pending_roots.size();
  end

  initial begin
    errors = 0;
    outstanding = 0;
    roots_seen = 0;
    invalids_seen = 0;
  end
endmodule

>>> tb/tb_newton_square_root_unit.sv
`timescale 1ns / 100ps
module tb_newton_square_root_unit;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 1000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [31:0] in_value = '0;
  logic        busy, out_valid, out_invalid;
  logic [31:0] out_root;
  int          errors, outstanding, roots_seen, invalids_seen;
  int          cycles = 0;

  logic [31:0] directed[] = '{32'h0, 32'h1, 32'hFFFF, 32'h1_0000, 32'h1_0001,
    32'h1_0002, 32'h1_0010, 32'h2_0000, 32'h4_0000, 32'h10_0000, 32'hFFFF_FFFF,
    32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
    32'h0001_8000, 32'h0003_0000, 32'h0064_0000, 32'h1234_5678};

  newton_square_root_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_value(in_value), .busy(busy),
    .out_valid(out_valid), .out_root(out_root), .out_invalid(out_invalid)
  );

  sqrt_result_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .in_value(in_value), .busy(busy),
    .out_valid(out_valid), .out_root(out_root), .out_invalid(out_invalid),
    .errors(errors), .outstanding(outstanding), .roots_seen(roots_seen),
    .invalids_seen(invalids_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_request(input logic [31:0] v, input bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < 24) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    start <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_operand();
    int width;
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'h1_0000 + $urandom_range(16) - 8;
      default: begin
        width = $urandom_range(32, 1);
        return $urandom() >> (32 - width);
      end
    endcase
  endfunction

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) send_request(directed[i], 1'b1);
    for (int i = 0; i < 1600; i++) send_request(random_operand(), i < 500 || i >= 900);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Checked %0d roots, %0d of them flagged invalid, in %0d cycles.",
             roots_seen, invalids_seen, cycles);
    if (errors == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
